// ===== rtl/bdmc_pkg.sv =====
package bdmc_pkg;

    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int TAP_W     = 3;
    localparam int EV_W      = 3;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 8;

    localparam logic [TAP_W-1:0] TAP_MAX = 3'd7;
    localparam logic [TAP_W-1:0] TAP_TWO   = 3'd2;
    localparam logic [TAP_W-1:0] TAP_THREE = 3'd3;
    localparam logic [TAP_W-1:0] TAP_FOUR  = 3'd4;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
    localparam logic [CFG_W-1:0] TAP_TIMEOUT_RST = 16'd300;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_TIMEOUT = 2'd1;

    localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EV_W-1:0] EV_CHORD21 = 3'd1;
    localparam logic [EV_W-1:0] EV_CHORD31 = 3'd2;
    localparam logic [EV_W-1:0] EV_BTN2    = 3'd3;
    localparam logic [EV_W-1:0] EV_BTN3    = 3'd4;
    localparam logic [EV_W-1:0] EV_DOUBLE  = 3'd5;
    localparam logic [EV_W-1:0] EV_TRIPLE  = 3'd6;
    localparam logic [EV_W-1:0] EV_QUAD    = 3'd7;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              third_pressed;
        logic              second_pressed;
        logic              first_pressed;
    } t_poll;

    typedef struct packed {
        logic [CFG_W-1:0] tap_timeout;
        logic [CFG_W-1:0] debounce_time;
    } t_cfg;

    typedef struct packed {
        logic            first_stable;
        logic [EV_W-1:0] event_code;
    } t_res;

endpackage

// ===== rtl/bdmc_core.sv =====
module bdmc_core import bdmc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  t_poll i_poll,
    input  t_cfg  i_cfg,
    output t_res  o_res
);

    logic              r_raw_prev;
    logic              r_stable;
    logic [TIME_W-1:0] r_change_time;
    logic [TAP_W-1:0]  r_tap_count;
    logic [TIME_W-1:0] r_press_time;

    logic              n_stable;
    logic [TIME_W-1:0] n_change_time;
    logic [TAP_W-1:0]  n_tap_count;
    logic [TIME_W-1:0] n_press_time;
    logic [EV_W-1:0]   n_event;

    logic [TIME_W-1:0] db_diff;
    logic [TIME_W-1:0] tap_diff;
    logic              take;
    logic              press;
    logic [TAP_W-1:0]  cnt_a;
    logic [TIME_W-1:0] pt_a;

    always_comb begin
        db_diff  = i_poll.now_ms - r_change_time;
        tap_diff = i_poll.now_ms - r_press_time;
        // a raw change restarts the timer, so the level cannot settle in the same beat
        take = (i_poll.first_pressed == r_raw_prev)
            && (db_diff > {{(TIME_W-CFG_W){1'b0}}, i_cfg.debounce_time})
            && (i_poll.first_pressed != r_stable);
        press         = take && i_poll.first_pressed;
        n_stable      = take ? i_poll.first_pressed : r_stable;
        n_change_time = (i_poll.first_pressed != r_raw_prev) ? i_poll.now_ms : r_change_time;
        cnt_a = (press && (r_tap_count != TAP_MAX)) ? r_tap_count + 3'd1 : r_tap_count;
        pt_a  = press ? i_poll.now_ms : r_press_time;

        n_event      = EV_NONE;
        n_tap_count  = cnt_a;
        n_press_time = pt_a;
        if (n_stable && i_poll.second_pressed) begin
            n_event = EV_CHORD21;
        end else if (n_stable && i_poll.third_pressed) begin
            n_event = EV_CHORD31;
        end else if (i_poll.second_pressed) begin
            n_event = EV_BTN2;
        end else if (i_poll.third_pressed) begin
            n_event = EV_BTN3;
        end
        if (n_event != EV_NONE) begin
            n_tap_count  = '0;
            n_press_time = '0;
        end else if (!n_stable && (cnt_a != '0)
                     && (tap_diff > {{(TIME_W-CFG_W){1'b0}}, i_cfg.tap_timeout})) begin
            // press time is old here: a fresh press leaves the level high
            case (cnt_a)
                TAP_TWO:   n_event = EV_DOUBLE;
                TAP_THREE: n_event = EV_TRIPLE;
                TAP_FOUR:  n_event = EV_QUAD;
                default:   n_event = EV_NONE;
            endcase
            n_tap_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_prev    <= 1'b0;
            r_stable      <= 1'b0;
            r_change_time <= '0;
            r_tap_count   <= '0;
            r_press_time  <= '0;
        end else if (i_adv) begin
            r_raw_prev    <= i_poll.first_pressed;
            r_stable      <= n_stable;
            r_change_time <= n_change_time;
            r_tap_count   <= n_tap_count;
            r_press_time  <= n_press_time;
        end
    end

    assign o_res.event_code   = n_event;
    assign o_res.first_stable = n_stable;

    a_chord_needs_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (n_event == EV_CHORD21 || n_event == EV_CHORD31)) |-> n_stable)
        else $error("chord reported with button 1 released");

    a_button_clears_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && n_event != EV_NONE) |=> (r_tap_count == '0))
        else $error("tap count survived an event");

    a_tap_event_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (n_event == EV_DOUBLE || n_event == EV_TRIPLE || n_event == EV_QUAD))
        |-> (!n_stable && !i_poll.second_pressed && !i_poll.third_pressed))
        else $error("tap report while a button is held");

endmodule

// ===== rtl/button_debounce_multitap_chord.sv =====
// Debounce of button 1 with multi-tap counting and chords with buttons 2 and 3.
//
// Slave stream: one beat per poll; tdata carries the raw button levels and a
// wrapping millisecond timestamp. Master stream: exactly one beat per poll,
// carrying the event code and the debounced level of button 1.
// Configuration: a separate write channel (index, data), always ready; index 0
// is the debounce time, index 1 the tap timeout, other indexes are dropped.
// Write it only while no poll is in flight.
//
// Path: a poll is accepted into the input register, then moves into the result
// register, whose valid flag drives the master stream. Throughput: one poll per
// cycle while the receiver does not stall; the debounce and tap state update
// as the poll moves into the result register.
// When the receiver stalls, the result register holds and the input register
// takes one more poll before tready drops.
// Reset (synchronous, active low) empties both registers, clears the debounce
// and tap state and restores the registers to 50 ms and 300 ms.
module button_debounce_multitap_chord import bdmc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [0] first_pressed, [1] second_pressed, [2] third_pressed, [34:3] now_ms
    input  logic [S_DATA_W-1:0]  i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [2:0] event_code, [3] first_stable
    output logic [M_DATA_W-1:0]  o_m_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic  r_in_vld;
    t_poll r_in;
    logic  r_out_vld;
    t_res  r_out;
    t_cfg  r_cfg;
    t_res  core_res;
    logic  adv;

    assign adv         = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready  = !r_in_vld || adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time <= DEBOUNCE_RST;
            r_cfg.tap_timeout   <= TAP_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE:    r_cfg.debounce_time <= i_cfg_data;
                REG_TAP_TIMEOUT: r_cfg.tap_timeout   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in <= t_poll'(i_s_tdata[34:0]);
        end
    end

    bdmc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_poll  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || i_m_tready) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(M_DATA_W-$bits(t_res)){1'b0}}, r_out};

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |=> (r_out_vld && $stable(r_out)))
        else $error("result lost under stall");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !i_m_tready) |-> !o_s_tready)
        else $error("poll accepted with both registers full");

    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> o_s_tready)
        else $error("empty input register refused a beat");

endmodule
